@@ design/qfir_pkg.sv @@
// ----------------------------------------------------------------------------
// qfir_pkg
// Shared constants, types and command/status structs for the Q15 FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package qfir_pkg;

  localparam int MAX_TAPS  = 64;
  localparam int TAP_AW    = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
  localparam int BLK_TAPS  = 8;
  localparam int BLK_MAX   = MAX_TAPS / BLK_TAPS;
  localparam int BLK_W     = 4;
  localparam int BLK_RESET = 8;
  localparam int IDX_W     = 6;
  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 32;
  localparam int FRAC_BITS = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]           coef_idx_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              push;
    logic              coef_wr;
    logic              acc_clr;
    logic              rd_en;
    logic [TAP_AW-1:0] rd_idx;
    logic              load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_can_load;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/qfir_in_if.sv @@
// ----------------------------------------------------------------------------
// qfir_in_if
// Request channel into the filter: sample pushes and coefficient writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface qfir_in_if;
  import qfir_pkg::*;

  logic      valid;
  logic      ready;
  op_t       op;
  coef_idx_t coef_index;
  sample_t   value;

  modport source (output valid, output op, output coef_index, output value, input ready);
  modport sink   (input valid, input op, input coef_index, input value, output ready);
endinterface

`default_nettype wire

@@ design/qfir_out_if.sv @@
// ----------------------------------------------------------------------------
// qfir_out_if
// Result channel out of the filter: one filtered sample per sample request.
// ----------------------------------------------------------------------------
`default_nettype none

interface qfir_out_if;
  import qfir_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

@@ design/qfir_ram.sv @@
// ----------------------------------------------------------------------------
// qfir_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module qfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/qfir_ctrl.sv @@
// ----------------------------------------------------------------------------
// qfir_ctrl
// Controller: request handshake, tap count register and tap sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module qfir_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire qfir_pkg::op_t             in_op,
  output logic                           in_ready,
  input  wire logic                      cfg_we,
  input  wire logic [qfir_pkg::BLK_W-1:0] cfg_wdata,
  input  wire qfir_pkg::dp_stat_t        stat,
  output qfir_pkg::ctrl_cmd_t            cmd
);
  import qfir_pkg::*;

  state_t               state_r, state_nxt;
  logic [TAP_CNT_W-1:0] idx_r, idx_nxt;
  logic [BLK_W-1:0]     tap_blocks_r;
  logic [BLK_W-1:0]     blk_eff;
  logic [TAP_CNT_W-1:0] taps;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_blocks_r <= BLK_W'(BLK_RESET);
    end else if (cfg_we) begin
      tap_blocks_r <= cfg_wdata;
    end
  end

  // tap count saturates at the delay line length
  assign blk_eff = (tap_blocks_r > BLK_W'(BLK_MAX)) ? BLK_W'(BLK_MAX) : tap_blocks_r;
  assign taps    = TAP_CNT_W'(32'(blk_eff) * BLK_TAPS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    accept       = 1'b0;
    cmd          = '0;
    cmd.rd_idx   = idx_r[TAP_AW-1:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (accept && (in_op == OP_COEF)) begin
          cmd.coef_wr = 1'b1;
        end
        if (accept && (in_op == OP_SAMPLE)) begin
          cmd.push    = 1'b1;
          cmd.acc_clr = 1'b1;
          idx_nxt     = '0;
          state_nxt   = (taps == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.rd_en = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_nxt == taps) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_can_load) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/qfir_dp.sv @@
// ----------------------------------------------------------------------------
// qfir_dp
// Datapath: circular delay line, coefficient RAM, shared MAC and result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module qfir_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire qfir_pkg::ctrl_cmd_t   cmd,
  input  wire qfir_pkg::coef_idx_t   in_coef_index,
  input  wire qfir_pkg::sample_t     in_value,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output qfir_pkg::sample_t          out_filtered,
  output qfir_pkg::dp_stat_t         stat
);
  import qfir_pkg::*;

  logic [TAP_AW-1:0]      head_r, head_nxt;
  logic [TAP_CNT_W-1:0]   fill_r, fill_nxt;
  logic                   s1_valid_r, s1_live_r, p_valid_r;
  logic signed [ACC_W-1:0] prod_r, acc_r;
  logic signed [ACC_W-1:0] mult;
  logic                   out_valid_r;
  sample_t                out_filtered_r;
  logic [SAMPLE_W-1:0]    dly_q, coef_q;
  logic                   idx_ok;
  logic                   live;
  logic signed [ACC_W-FRAC_BITS-1:0] shifted;
  sample_t                result;

  assign head_nxt = cmd.push ? head_r + 1'b1 : head_r;
  assign fill_nxt = (cmd.push && (fill_r != TAP_CNT_W'(MAX_TAPS))) ? fill_r + 1'b1 : fill_r;
  assign idx_ok   = 32'(in_coef_index) < MAX_TAPS;
  // taps older than the number of pushes since reset read as zero
  assign live     = TAP_CNT_W'(cmd.rd_idx) < fill_r;

  qfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (head_nxt),
    .wdata (in_value),
    .re    (cmd.rd_en),
    .raddr (head_r - cmd.rd_idx),
    .rdata (dly_q)
  );

  qfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (cmd.coef_wr && idx_ok),
    .waddr (TAP_AW'(in_coef_index)),
    .wdata (in_value),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_idx),
    .rdata (coef_q)
  );

  // sign-extended product of one tap
  assign mult = $signed(dly_q) * $signed(coef_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      s1_live_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      s1_valid_r  <= cmd.rd_en;
      s1_live_r   <= cmd.rd_en && live;
      p_valid_r   <= s1_valid_r;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      prod_r <= s1_live_r ? mult : '0;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (p_valid_r) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.load_out) begin
      out_filtered_r <= result;
    end
  end

  // arithmetic shift by the fraction bits, then saturate to 16 bits
  assign shifted = acc_r[ACC_W-1:FRAC_BITS];
  assign result  = (shifted[ACC_W-FRAC_BITS-1] != shifted[SAMPLE_W-1]) ?
                   (shifted[ACC_W-FRAC_BITS-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                               : {1'b0, {(SAMPLE_W-1){1'b1}}}) :
                   shifted[SAMPLE_W-1:0];

  assign out_valid         = out_valid_r;
  assign out_filtered      = out_filtered_r;
  assign stat.pipe_busy    = s1_valid_r || p_valid_r;
  assign stat.out_can_load = !out_valid_r || out_ready;

endmodule

`default_nettype wire

@@ design/q15_fir_filter.sv @@
// ----------------------------------------------------------------------------
// q15_fir_filter
// Q1.15 direct-form FIR filter with up to 64 taps and one shared MAC.
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries requests: op = sample pushes value into the delay line and
//   produces one filtered result on out_ch; op = coefficient writes value to
//   coefficient coef_index and produces nothing. cfg_we/cfg_wdata set
//   tap_blocks (taps = 8 * tap_blocks, at most 64); write it only when idle.
// timing:
//   a coefficient write leaves in_ch.ready high. from a sample's accept until
//   its result is valid, in_ch.ready is low (tap reads, none when tap_blocks
//   is 0, then MAC drain and result load); the single multiply-accumulate unit
//   handles one tap per cycle and both RAMs give one read per cycle.
// reset:
//   rst_n clears the delay line (by a fill count), sets tap_blocks to 8 and
//   empties the result register; coefficients must be written before use.
// stall:
//   the result register holds while out_ch.ready is low; the block can still
//   take coefficient writes and finish the next sample, then waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module q15_fir_filter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  qfir_in_if.sink                          in_ch,
  qfir_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [qfir_pkg::BLK_W-1:0]  cfg_wdata
);
  import qfir_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  qfir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd)
  );

  qfir_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_coef_index (in_ch.coef_index),
    .in_value      (in_ch.value),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_filtered  (out_ch.filtered),
    .stat          (stat)
  );

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !stat.pipe_busy)
    else $error("mac pipeline busy while taking requests");

  a_no_read_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !in_ch.ready)
    else $error("tap read issued while idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_can_load)
    else $error("result loaded over an untaken result");

  a_push_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> !in_ch.ready)
    else $error("sample request did not start filtering");

endmodule

`default_nettype wire

@@ verif/tb_q15_fir_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_q15_fir_filter
// Self-checking bench for the Q15 FIR filter. A scoreboard class tracks the
// delay line, the coefficient table and tap_blocks, and predicts the
// saturated Q1.15 output of every sample request. Stimulus is a short
// directed set followed by random phases over several tap_blocks settings,
// with random gaps on both channels and a long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_q15_fir_filter;
  import qfir_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_CYC   = 5;
  localparam int SETTLE_CYC  = 100;      // longer than a whole 64-tap sample
  localparam int HOLD_CYC    = 600;
  localparam int PHASE_ITEMS = 125;
  localparam int LIMIT_CYC   = 2_000_000;
  localparam int MAX_PRINTS  = 50;

  class fir_scoreboard;
    sample_t          line_q[MAX_TAPS];
    sample_t          coef_q[MAX_TAPS];
    logic [BLK_W-1:0] blocks;
    sample_t          filtered_due[$];
    int               n_req;
    int               n_res;

    function new();
      for (int i = 0; i < MAX_TAPS; i++) begin
        line_q[i] = '0;
        coef_q[i] = '0;
      end
      blocks = BLK_W'(BLK_RESET);
      n_req  = 0;
      n_res  = 0;
    endfunction

    function void set_blocks(logic [BLK_W-1:0] b);
      blocks = b;
    endfunction

    // wrapping 32-bit sum, arithmetic shift, saturate to 16 bits
    function sample_t fir_output();
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] prod;
      int ntaps;
      int sh;
      ntaps = int'(blocks) * BLK_TAPS;
      if (ntaps > MAX_TAPS) ntaps = MAX_TAPS;
      acc = '0;
      for (int i = 0; i < ntaps; i++) begin
        prod = line_q[i] * coef_q[i];
        acc  = acc + prod;
      end
      sh = int'(acc >>> FRAC_BITS);
      if (sh > 32767) return 16'sh7fff;
      if (sh < -32768) return 16'sh8000;
      return sample_t'(sh);
    endfunction

    function void note_request(op_t op, coef_idx_t idx, sample_t val);
      n_req++;
      if (op == OP_COEF) begin
        coef_q[idx] = val;
      end else begin
        for (int i = MAX_TAPS - 1; i > 0; i--) line_q[i] = line_q[i-1];
        line_q[0] = val;
        filtered_due.push_back(fir_output());
      end
    endfunction

    function bit check_result(sample_t got, output string why);
      sample_t want;
      n_res++;
      why = "";
      if (filtered_due.size() == 0) begin
        why = $sformatf("result %0d with no request pending", got);
        return 1'b0;
      end
      want = filtered_due.pop_front();
      if (got !== want) begin
        why = $sformatf("filtered %0d, expected %0d", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [BLK_W-1:0] cfg_wdata;

  qfir_in_if  in_bus();
  qfir_out_if out_bus();

  q15_fir_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  fir_scoreboard sb = new();
  int    errors     = 0;
  int    cycles     = 0;
  int    hold_count = 0;
  bit    hold_req   = 1'b0;
  bit    sink_on    = 1'b0;
  string why;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycles, what);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        sb.note_request(op_t'(in_bus.op), in_bus.coef_index, in_bus.value);
      if (out_bus.valid && out_bus.ready) begin
        if (!sb.check_result(out_bus.filtered, why)) report_mismatch(why);
      end
    end
    if (cycles >= LIMIT_CYC) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.filtered_due.size());
      $display("tb_q15_fir_filter: done, errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  function automatic sample_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return sample_t'($urandom_range(0, 4095) - 2048);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // receiver: random stalls, bursts of full rate, one long hold on request
  initial begin
    int stall;
    int run;
    wait (sink_on);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk) out_bus.ready <= 1'b0;
        for (hold_count = 1; hold_count < HOLD_CYC; hold_count++) @(negedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk) out_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_bus.ready <= 1'b1;
      run = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(1, 8);
      repeat (run - 1) @(negedge clk);
    end
  end

  task automatic send_req(input op_t op, input coef_idx_t idx, input sample_t val);
    @(negedge clk);
    in_bus.op         <= op;
    in_bus.coef_index <= idx;
    in_bus.value      <= val;
    in_bus.valid      <= 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic tx_gap(input int n);
    if (n > 0) begin
      @(negedge clk) in_bus.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk) in_bus.valid <= 1'b0;
    while (sb.filtered_due.size() != 0) @(posedge clk);
  endtask

  // only while idle: drain, let a trailing coefficient write finish, write
  task automatic write_blocks(input logic [BLK_W-1:0] b);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(negedge clk) cfg_we <= 1'b0;
    sb.set_blocks(b);
  endtask

  task automatic sample_gap(input sample_t v);
    send_req(OP_SAMPLE, coef_idx_t'($urandom_range(0, 63)), v);
    tx_gap(pick_gap());
  endtask

  task automatic coef_gap(input coef_idx_t idx, input sample_t v);
    send_req(OP_COEF, idx, v);
    tx_gap(pick_gap());
  endtask

  task automatic run_phase(input logic [BLK_W-1:0] b, input bit no_gaps,
                           input bit with_hold, input bit with_pause);
    write_blocks(b);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (with_hold && i == 10) hold_req = 1'b1;
      // sender stops until every result is back, then carries on
      if (with_pause && i == PHASE_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 99) < 15)
        send_req(OP_COEF, coef_idx_t'($urandom_range(0, 63)), pick_value());
      else
        send_req(OP_SAMPLE, coef_idx_t'($urandom()), pick_value());
      if (!no_gaps) tx_gap(pick_gap());
    end
  endtask

  initial begin
    logic [BLK_W-1:0] plan [10];
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.op         = OP_SAMPLE;
    in_bus.coef_index = '0;
    in_bus.value      = '0;
    out_bus.ready     = 1'b0;
    plan = '{4'd8, 4'd15, 4'd2, 4'd0, 4'd9, 4'd5, 4'd1, 4'd8, 4'd0, 4'd0};
    plan[8] = BLK_W'($urandom_range(0, 15));
    plan[9] = BLK_W'($urandom_range(0, 15));

    repeat (RESET_CYC) @(negedge clk);
    rst_n   <= 1'b1;
    sink_on = 1'b1;

    // zero tap blocks: no coefficient is read, output stays 0
    write_blocks(4'd0);
    sample_gap(16'sh7fff);
    sample_gap(16'sh8000);
    sample_gap(16'sh0000);
    sample_gap(pick_value());

    // one block of eight taps with extreme coefficients
    write_blocks(4'd1);
    coef_gap(6'd0, 16'sh7fff);
    coef_gap(6'd1, 16'sh8000);
    coef_gap(6'd2, 16'sh8000);
    coef_gap(6'd3, 16'sh7fff);
    coef_gap(6'd4, 16'sh0001);
    coef_gap(6'd5, 16'shffff);
    coef_gap(6'd6, 16'sh8000);
    coef_gap(6'd7, 16'sh8000);
    // full-scale negatives drive the sum past 2^31 and toward saturation
    repeat (4) sample_gap(16'sh8000);
    sample_gap(16'sh7fff);
    sample_gap(16'sh7fff);
    sample_gap(16'sh0001);
    sample_gap(16'shffff);
    sample_gap(16'sh0000);
    sample_gap(16'sh8000);

    // rest of the table before wider settings read it
    for (int k = BLK_TAPS; k < MAX_TAPS; k++) coef_gap(coef_idx_t'(k), pick_value());

    for (int p = 0; p < 10; p++)
      run_phase(plan[p], p == 5, p == 1, p == 2);

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (sb.filtered_due.size() != 0)
      report_mismatch($sformatf("%0d results never came", sb.filtered_due.size()));

    $display("covered %0d requests and %0d filtered results, tap_blocks 0, 1, 2, 5, 8, 9, 15",
             sb.n_req, sb.n_res);
    $display("plus %0d and %0d, random gaps and a %0d-cycle receiver hold", plan[8], plan[9],
             hold_count);
    if (errors == 0) begin
      $display("tb_q15_fir_filter: done, clean");
    end else begin
      $display("tb_q15_fir_filter: done, errors");
    end
    $finish;
  end

endmodule
